// File: rtl/cewe_pkg.sv
package cewe_pkg;

   localparam int ENTRIES_DEF   = 1024;
   localparam int MAX_EVICT_DEF = 32;

   localparam int OPCODE_W = 3;
   localparam int INDEX_W  = 10;
   localparam int TIME_W   = 32;
   localparam int LEVEL_W  = 4;
   localparam int COUNT_W  = 6;
   localparam int ACTIVE_W = 11;
   localparam int STEP_W   = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [OPCODE_W-1:0] OP_ACCESS = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_FLUSH  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_EVICT  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_ENTRIES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STAMP_STEP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USAGE_LEVELS   = 2'd2;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 11'd1024;
   localparam logic [STEP_W-1:0]   STEP_RESET   = 9'd1;
   localparam logic [LEVEL_W-1:0]  LEVELS_RESET = 4'd3;

   typedef struct packed {
      logic                valid;
      logic [LEVEL_W-1:0]  level;
      logic [TIME_W-1:0]   expiry;
      logic [TIME_W-1:0]   stamp;
   } entry_type;

endpackage

// File: rtl/cewe_ram.sv
module cewe_ram #(
   parameter int DEPTH = cewe_pkg::ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  cewe_pkg::entry_type       wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output cewe_pkg::entry_type       rd_data
);

   cewe_pkg::entry_type mem_ff [DEPTH];
   cewe_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/clock_eviction_with_expiry_unit.sv
// channel   | direction | handshake             | payload
// req_      | in        | req_valid / req_stall | opcode, entry index, expiry, usage, now, count
// rsp_      | out       | rsp_valid / rsp_stall | index, stamp, victim, success, last
// csr_      | in        | csr_write             | csr_index, csr_wdata
//
// an in-table access reads its entry in S_ACC_READ before S_EXEC; insert, remove, flush go to S_EXEC
// evict loops S_HEAD and S_USE for each entry swept by the clock hand, up to two passes, then S_END
// after reset a clearing pass frees every entry; no transaction is taken meanwhile
// one transaction is worked on at a time; req_stall is high while the sequencer is busy
// a result waits in the output register; the sequencer only stalls when a second result is due
module clock_eviction_with_expiry_unit #(
   parameter int ENTRIES   = cewe_pkg::ENTRIES_DEF,
   parameter int MAX_EVICT = cewe_pkg::MAX_EVICT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cewe_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [cewe_pkg::INDEX_W-1:0]      req_entry_index,
   input  logic [cewe_pkg::TIME_W-1:0]       req_expiry_time,
   input  logic [cewe_pkg::LEVEL_W-1:0]      req_insert_usage,
   input  logic [cewe_pkg::TIME_W-1:0]       req_now_seconds,
   input  logic [cewe_pkg::COUNT_W-1:0]      req_evict_count,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cewe_pkg::INDEX_W-1:0]      rsp_result_index,
   output logic [cewe_pkg::TIME_W-1:0]       rsp_result_stamp,
   output logic                              rsp_is_victim,
   output logic                              rsp_success,
   output logic                              rsp_last,
   // configuration
   input  logic                              csr_write,
   input  logic [cewe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cewe_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int HAND_W = $clog2(ENTRIES + 1);
   localparam int CNT_W  = $clog2(MAX_EVICT + 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_ACC_READ, S_EXEC, S_HEAD, S_USE, S_END
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [cewe_pkg::ACTIVE_W-1:0] active_ff;
   logic [cewe_pkg::STEP_W-1:0]   step_ff;
   logic [cewe_pkg::LEVEL_W-1:0]  levels_ff;

   // engine state
   logic [HAND_W-1:0]            hand_ff;
   logic [cewe_pkg::TIME_W-1:0]  next_stamp_ff;
   logic [cewe_pkg::TIME_W-1:0]  flush_mark_ff;
   logic [IDX_W-1:0]             clr_ff;

   // latched transaction
   logic [cewe_pkg::OPCODE_W-1:0] op_ff;
   logic [cewe_pkg::INDEX_W-1:0]  idx_ff;
   logic                          in_table_ff;
   logic [cewe_pkg::TIME_W-1:0]   expiry_ff;
   logic [cewe_pkg::LEVEL_W-1:0]  ins_ff;
   logic [cewe_pkg::TIME_W-1:0]   now_ff;
   logic [CNT_W-1:0]              want_ff;

   // sweep bookkeeping
   logic [CNT_W-1:0]  found_ff;
   logic              wrapped_ff;
   logic [IDX_W-1:0]  h_ff;
   logic              pend_valid_ff;
   logic [IDX_W-1:0]  pend_idx_ff;

   // output register
   logic                          rsp_valid_ff;
   logic [cewe_pkg::INDEX_W-1:0]  rsp_index_ff;
   logic [cewe_pkg::TIME_W-1:0]   rsp_stamp_ff;
   logic                          rsp_victim_ff;
   logic                          rsp_success_ff;
   logic                          rsp_last_ff;

   // ram port
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   cewe_pkg::entry_type  wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   cewe_pkg::entry_type  rd_data;

   logic                          room;
   logic [HAND_W-1:0]             end_w;
   logic [cewe_pkg::LEVEL_W-1:0]  top;
   logic [cewe_pkg::LEVEL_W-1:0]  ins_level;
   logic                          head_wrap;
   logic [IDX_W-1:0]              head_h;
   logic [IDX_W-1:0]              idx_addr;
   logic                          is_victim;
   logic                          victim_wait;
   logic                          req_in_table;
   logic [CNT_W-1:0]              req_want;
   logic [HAND_W-1:0]             h_next;

   always_comb begin
      room = !rsp_valid_ff || !rsp_stall;
      // sweep range clamped to 1 .. ENTRIES
      if (active_ff == '0) begin
         end_w = HAND_W'(1);
      end else if (32'(active_ff) > 32'(ENTRIES)) begin
         end_w = HAND_W'(ENTRIES);
      end else begin
         end_w = HAND_W'(active_ff);
      end
      top       = (levels_ff == '0) ? '0 : levels_ff - 1'b1;
      ins_level = (ins_ff > top) ? top : ins_ff;
      head_wrap = hand_ff >= end_w;
      head_h    = head_wrap ? '0 : IDX_W'(hand_ff);
      h_next    = HAND_W'(h_ff) + 1'b1;
      idx_addr  = IDX_W'(idx_ff);
      req_in_table = 32'(req_entry_index) < 32'(ENTRIES);
      req_want  = (32'(req_evict_count) > 32'(MAX_EVICT)) ? CNT_W'(MAX_EVICT)
                                                         : CNT_W'(req_evict_count);
      is_victim = (rd_data.level == '0)
               || (rd_data.expiry != '0 && rd_data.expiry <= now_ff)
               || (rd_data.stamp < flush_mark_ff);
      victim_wait = rd_data.valid && is_victim && pend_valid_ff && !room;

      rd_en   = (state_ff == S_ACC_READ) || (state_ff == S_HEAD);
      rd_addr = (state_ff == S_HEAD) ? head_h : idx_addr;

      wr_en   = 1'b0;
      wr_addr = idx_addr;
      wr_data = '0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
         end
         S_EXEC: begin
            if (room && in_table_ff) begin
               unique case (op_ff)
                  cewe_pkg::OP_ACCESS: begin
                     wr_en         = rd_data.valid && (rd_data.level < top);
                     wr_data       = rd_data;
                     wr_data.level = rd_data.level + 1'b1;
                  end
                  cewe_pkg::OP_INSERT: begin
                     wr_en          = 1'b1;
                     wr_data.valid  = 1'b1;
                     wr_data.level  = ins_level;
                     wr_data.expiry = expiry_ff;
                     wr_data.stamp  = next_stamp_ff;
                  end
                  cewe_pkg::OP_REMOVE: begin
                     wr_en = 1'b1;
                  end
                  default: begin
                     wr_en = 1'b0;
                  end
               endcase
            end
         end
         S_USE: begin
            wr_addr = h_ff;
            if (rd_data.valid && !victim_wait) begin
               wr_en = 1'b1;
               if (!is_victim) begin
                  wr_data       = rd_data;
                  wr_data.level = rd_data.level - 1'b1;
               end
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   cewe_ram #(
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // configuration writes, taken in any state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= cewe_pkg::ACTIVE_RESET;
         step_ff   <= cewe_pkg::STEP_RESET;
         levels_ff <= cewe_pkg::LEVELS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            cewe_pkg::CSR_ACTIVE_ENTRIES: active_ff <= csr_wdata;
            cewe_pkg::CSR_STAMP_STEP:     step_ff   <= cewe_pkg::STEP_W'(csr_wdata);
            cewe_pkg::CSR_USAGE_LEVELS:   levels_ff <= cewe_pkg::LEVEL_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         hand_ff       <= '0;
         next_stamp_ff <= '0;
         flush_mark_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         found_ff      <= '0;
         want_ff       <= '0;
         wrapped_ff    <= 1'b0;
      end else begin
         if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == IDX_W'(ENTRIES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  op_ff       <= req_opcode;
                  idx_ff      <= req_entry_index;
                  in_table_ff <= req_in_table;
                  expiry_ff   <= req_expiry_time;
                  ins_ff      <= req_insert_usage;
                  now_ff      <= req_now_seconds;
                  want_ff     <= req_want;
                  found_ff    <= '0;
                  wrapped_ff  <= 1'b0;
                  pend_valid_ff <= 1'b0;
                  if (req_opcode == cewe_pkg::OP_EVICT) begin
                     state_ff <= S_HEAD;
                  end else if (req_opcode == cewe_pkg::OP_ACCESS && req_in_table) begin
                     state_ff <= S_ACC_READ;
                  end else begin
                     state_ff <= S_EXEC;
                  end
               end
            end
            S_ACC_READ: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (room) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_victim_ff  <= 1'b0;
                  rsp_success_ff <= 1'b1;
                  rsp_last_ff    <= 1'b1;
                  rsp_stamp_ff   <= '0;
                  rsp_index_ff   <= '0;
                  if (op_ff == cewe_pkg::OP_ACCESS || op_ff == cewe_pkg::OP_INSERT
                      || op_ff == cewe_pkg::OP_REMOVE) begin
                     rsp_index_ff <= idx_ff;
                  end
                  if (op_ff == cewe_pkg::OP_INSERT && in_table_ff) begin
                     rsp_stamp_ff  <= next_stamp_ff;
                     next_stamp_ff <= next_stamp_ff + cewe_pkg::TIME_W'(step_ff);
                  end
                  if (op_ff == cewe_pkg::OP_FLUSH) begin
                     flush_mark_ff <= next_stamp_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_HEAD: begin
               // stop when enough victims or the hand passes the end a second time
               if (found_ff >= want_ff || (head_wrap && wrapped_ff)) begin
                  state_ff <= S_END;
               end else begin
                  wrapped_ff <= wrapped_ff | head_wrap;
                  h_ff       <= head_h;
                  state_ff   <= S_USE;
               end
            end
            S_USE: begin
               if (!victim_wait) begin
                  if (rd_data.valid && is_victim) begin
                     // the previous victim is known not to be the last one now
                     if (pend_valid_ff) begin
                        rsp_valid_ff   <= 1'b1;
                        rsp_index_ff   <= cewe_pkg::INDEX_W'(pend_idx_ff);
                        rsp_stamp_ff   <= '0;
                        rsp_victim_ff  <= 1'b1;
                        rsp_success_ff <= 1'b1;
                        rsp_last_ff    <= 1'b0;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_idx_ff   <= h_ff;
                     found_ff      <= found_ff + 1'b1;
                  end
                  hand_ff  <= h_next;
                  state_ff <= S_HEAD;
               end
            end
            S_END: begin
               if (room) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_stamp_ff <= '0;
                  rsp_last_ff  <= 1'b1;
                  if (pend_valid_ff) begin
                     rsp_index_ff   <= cewe_pkg::INDEX_W'(pend_idx_ff);
                     rsp_victim_ff  <= 1'b1;
                     rsp_success_ff <= found_ff == want_ff;
                  end else begin
                     rsp_index_ff   <= '0;
                     rsp_victim_ff  <= 1'b0;
                     rsp_success_ff <= 1'b0;
                  end
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall        = state_ff != S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_stamp = rsp_stamp_ff;
   assign rsp_is_victim    = rsp_victim_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTH
   // victim count never passes the requested count
   assert property (@(posedge clock) disable iff (reset) found_ff <= want_ff)
      else $error("victim count above request");
   // clock hand never passes ENTRIES
   assert property (@(posedge clock) disable iff (reset) 32'(hand_ff) <= 32'(ENTRIES))
      else $error("clock hand out of range");
   // a held victim implies at least one found
   assert property (@(posedge clock) disable iff (reset) pend_valid_ff |-> found_ff != '0)
      else $error("pending victim without count");
   // a waiting victim never overwrites an untaken result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_index_ff))
      else $error("result overwritten while stalled");
`endif

endmodule
